// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define MI3_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MI3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, stage counts, operand tables and shared types of the 3x3 inverter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int N_ELEM    = 9;
    localparam int N_MUL     = 2 * N_ELEM;

    // exact cofactor and determinant widths
    localparam int COF_W = 2 * ELEM_W;
    localparam int DET_W = 3 * ELEM_W + 1;
    // cofactor magnitude scaled by 2^(2*FRAC_BITS)
    localparam int NUM_W = COF_W + 2 * FRAC_BITS;

    // quotient bits below the saturation limit, one per divider stage
    localparam int DIV_STEPS = ELEM_W - 1;
    localparam int CMP_W     = DET_W + DIV_STEPS;

    localparam int ADJ_LAT  = 7;
    localparam int DIV_LAT  = DIV_STEPS + 1;
    localparam int PIPE_LAT = ADJ_LAT + DIV_LAT;

    localparam int OUT_W = (N_ELEM + 1) * ELEM_W;

    // operand pairs: cofactor i = m[A[2i]]*m[B[2i]] - m[A[2i+1]]*m[B[2i+1]]
    localparam int MUL_A [0:N_MUL-1] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int MUL_B [0:N_MUL-1] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic [NUM_W-1:0]         t_num;

    typedef struct packed {
        logic             zero;
        logic             dneg;
        logic [DET_W-1:0] dmag;
    } t_det_info;

    typedef struct packed {
        logic                 ovf;
        logic                 neg;
        logic [DIV_STEPS-1:0] quo;
    } t_lane_out;

endpackage

// ===== rtl/mi3_adj.sv =====
// ----------------------------------------------------------------------------
// mi3_adj
// Pipelined adjugate and exact determinant; prepares divider operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_adj (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  mi3_pkg::t_elem       i_elem [0:mi3_pkg::N_ELEM-1],
    output mi3_pkg::t_num        o_num  [0:mi3_pkg::N_ELEM-1],
    output logic                 o_neg  [0:mi3_pkg::N_ELEM-1],
    output mi3_pkg::t_det_info   o_det
);

    localparam int DW = mi3_pkg::DET_W;

    mi3_pkg::t_elem r_m1 [0:mi3_pkg::N_ELEM-1];
    logic signed [mi3_pkg::COF_W-1:0] r_p2 [0:mi3_pkg::N_MUL-1];
    mi3_pkg::t_elem r_m2 [0:2];
    mi3_pkg::t_elem r_m3 [0:2];
    mi3_pkg::t_cof  r_c3 [0:mi3_pkg::N_ELEM-1];
    mi3_pkg::t_cof  r_c4 [0:mi3_pkg::N_ELEM-1];
    mi3_pkg::t_cof  r_c5 [0:mi3_pkg::N_ELEM-1];
    mi3_pkg::t_cof  r_c6 [0:mi3_pkg::N_ELEM-1];
    logic signed [mi3_pkg::ELEM_W*2:0]   r_lo4 [0:2];
    logic signed [mi3_pkg::COF_W-1:0]    r_hi4 [0:2];
    logic signed [DW-1:0]                r_t5  [0:2];
    logic signed [DW-1:0]                r_det6;
    mi3_pkg::t_num      r_num7 [0:mi3_pkg::N_ELEM-1];
    logic               r_neg7 [0:mi3_pkg::N_ELEM-1];
    mi3_pkg::t_det_info r_det7;
    mi3_pkg::t_det_info n_det7;

    // stage 1: capture elements; stage 2: all cross products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= i_elem;
            for (int j = 0; j < mi3_pkg::N_MUL; j++) begin
                r_p2[j] <= r_m1[mi3_pkg::MUL_A[j]] * r_m1[mi3_pkg::MUL_B[j]];
            end
            for (int i = 0; i < 3; i++) begin
                r_m2[i] <= r_m1[i];
                r_m3[i] <= r_m2[i];
            end
        end
    end

    // stage 3: cofactors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
                r_c3[i] <= r_p2[2*i] - r_p2[2*i+1];
            end
        end
    end

    // stage 4: first-row times cofactor column, split into 32-bit halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_lo4[i] <= r_m3[i] * $signed({1'b0, r_c3[3*i][mi3_pkg::ELEM_W-1:0]});
                r_hi4[i] <= r_m3[i] * $signed(r_c3[3*i][mi3_pkg::COF_W-1:mi3_pkg::ELEM_W]);
            end
            r_c4 <= r_c3;
        end
    end

    // stage 5: recombine halves; stage 6: sum the three terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t5[i] <= $signed({r_hi4[i][mi3_pkg::COF_W-1], r_hi4[i],
                                    {mi3_pkg::ELEM_W{1'b0}}})
                         + $signed({{(DW-2*mi3_pkg::ELEM_W-1){r_lo4[i][2*mi3_pkg::ELEM_W]}},
                                    r_lo4[i]});
            end
            r_det6 <= r_t5[0] + r_t5[1] + r_t5[2];
            r_c5   <= r_c4;
            r_c6   <= r_c5;
        end
    end

    // stage 7: sign and magnitude of the determinant
    always_comb begin
        n_det7.zero = (r_det6 == '0);
        n_det7.dneg = r_det6[DW-1];
        n_det7.dmag = r_det6[DW-1] ? DW'(-r_det6) : DW'(r_det6);
    end

    // stage 7: scaled cofactor magnitudes and quotient signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det7 <= n_det7;
            for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
                r_num7[i] <= {(r_c6[i][mi3_pkg::COF_W-1] ? -r_c6[i] : r_c6[i]),
                              {(2*mi3_pkg::FRAC_BITS){1'b0}}};
                r_neg7[i] <= r_c6[i][mi3_pkg::COF_W-1] ^ r_det6[DW-1];
            end
        end
    end

    assign o_num = r_num7;
    assign o_neg = r_neg7;
    assign o_det = r_det7;

endmodule

// ===== rtl/mi3_div_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_div_lane
// One divider lane: overflow test then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_div_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  mi3_pkg::t_num                  i_num,
    input  logic                           i_neg,
    input  logic [mi3_pkg::DET_W-1:0]      i_dmag,
    output mi3_pkg::t_lane_out             o_res
);

    localparam int NS = mi3_pkg::DIV_STEPS;
    localparam int CW = mi3_pkg::CMP_W;
    localparam int NW = mi3_pkg::NUM_W;
    localparam int DW = mi3_pkg::DET_W;

    logic [NW-1:0] r_rem [0:NS];
    logic [DW-1:0] r_d   [0:NS];
    logic [NS-1:0] r_q   [0:NS];
    logic          r_ovf [0:NS];
    logic          r_neg [0:NS];

    // entry stage: quotient saturates when num >= dmag * 2^(ELEM_W-1)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_d[0]   <= i_dmag;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= {{(CW-NW){1'b0}}, i_num} >= ({{(CW-DW){1'b0}}, i_dmag} << NS);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int K = NS - 1 - j;
        logic [CW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = {{(CW-DW){1'b0}}, r_d[j]} << K;
        assign w_ge = {{(CW-NW){1'b0}}, r_rem[j]} >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? (r_rem[j] - w_sh[NW-1:0]) : r_rem[j];
                r_q[j+1]   <= r_q[j] | (NS'(w_ge) << K);
                r_d[j+1]   <= r_d[j];
                r_ovf[j+1] <= r_ovf[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    assign o_res.ovf = r_ovf[NS];
    assign o_res.neg = r_neg[NS];
    assign o_res.quo = r_q[NS];

endmodule

// ===== rtl/mi3_merge.sv =====
// ----------------------------------------------------------------------------
// mi3_merge
// Saturate lane quotients and determinant, pack the beat, output skid slice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  mi3_pkg::t_lane_out            i_lane [0:mi3_pkg::N_ELEM-1],
    input  mi3_pkg::t_det_info            i_det,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [mi3_pkg::OUT_W-1:0]     o_data,
    output logic                          o_user,
    input  logic                          i_ready
);

    localparam int EW = mi3_pkg::ELEM_W;
    localparam int SH = 2 * mi3_pkg::FRAC_BITS;

    logic [mi3_pkg::OUT_W-1:0] w_data;
    logic                      w_big;
    logic                      r_out_valid;
    logic [mi3_pkg::OUT_W-1:0] r_out_data;
    logic                      r_out_user;
    logic                      r_skid_valid;
    logic [mi3_pkg::OUT_W-1:0] r_skid_data;
    logic                      r_skid_user;

    // saturate each element and the shifted determinant
    always_comb begin
        w_data = '0;
        w_big  = |i_det.dmag[mi3_pkg::DET_W-1:SH+EW-1];
        for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
            if (i_lane[i].neg) begin
                w_data[i*EW +: EW] = i_lane[i].ovf ? {1'b1, {(EW-1){1'b0}}}
                                                   : -{1'b0, i_lane[i].quo};
            end else begin
                w_data[i*EW +: EW] = i_lane[i].ovf ? {1'b0, {(EW-1){1'b1}}}
                                                   : {1'b0, i_lane[i].quo};
            end
        end
        if (i_det.dneg) begin
            w_data[mi3_pkg::N_ELEM*EW +: EW] = w_big ? {1'b1, {(EW-1){1'b0}}}
                : -{1'b0, i_det.dmag[SH+EW-2:SH]};
        end else begin
            w_data[mi3_pkg::N_ELEM*EW +: EW] = w_big ? {1'b0, {(EW-1){1'b1}}}
                : {1'b0, i_det.dmag[SH+EW-2:SH]};
        end
        if (i_det.zero) begin
            w_data = '0;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // beat payload follows the same steering
    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else begin
                r_out_data <= w_data;
                r_out_user <= i_det.zero;
            end
        end else if (!r_skid_valid) begin
            r_skid_data <= w_data;
            r_skid_user <= i_det.zero;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;

endmodule

// ===== rtl/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse
// Streaming 3x3 Q16.16 matrix inverse by adjugate over exact determinant.
// ----------------------------------------------------------------------------
// One matrix beat is accepted every clock while the skid entry is empty. The
// cofactors and the exact 97-bit determinant come from a multiply-and-add
// pipeline, then nine parallel divider lanes (one overflow test and 31
// restoring quotient bits, one per stage) feed the output register. Elements
// are truncated toward zero and saturated; a zero determinant gives an
// all-zero beat with tuser set.
`timescale 1ns / 1ps

module matrix3_inverse (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each)
    input  logic [287:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // b00, b01, b02, b10, b11, b12, b20, b21, b22, determinant (32 bits each)
    output logic [319:0] o_m_axis_tdata,
    // singular
    output logic [0:0]   o_m_axis_tuser
);

    localparam int NE = mi3_pkg::N_ELEM;

    logic                      w_en;
    mi3_pkg::t_elem            w_elem [0:NE-1];
    mi3_pkg::t_num             w_num  [0:NE-1];
    logic                      w_neg  [0:NE-1];
    mi3_pkg::t_det_info        w_det;
    mi3_pkg::t_lane_out        w_lane [0:NE-1];
    logic                      r_vld  [0:mi3_pkg::PIPE_LAT-1];
    mi3_pkg::t_det_info        r_det_dly [0:mi3_pkg::DIV_LAT-1];
    logic                      w_user;

    // unpack the matrix beat
    for (genvar i = 0; i < NE; i++) begin : g_unpack
        assign w_elem[i] = i_s_axis_tdata[i*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
    end

    mi3_adj u_adj (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_elem (w_elem),
        .o_num  (w_num),
        .o_neg  (w_neg),
        .o_det  (w_det)
    );

    for (genvar i = 0; i < NE; i++) begin : g_lane
        mi3_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (w_num[i]),
            .i_neg  (w_neg[i]),
            .i_dmag (w_det.dmag),
            .o_res  (w_lane[i])
        );
    end

    // advance the valid line with the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mi3_pkg::PIPE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < mi3_pkg::PIPE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // hold determinant info alongside the divider lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det_dly[0] <= w_det;
            for (int k = 1; k < mi3_pkg::DIV_LAT; k++) begin
                r_det_dly[k] <= r_det_dly[k-1];
            end
        end
    end

    mi3_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[mi3_pkg::PIPE_LAT-1]),
        .i_lane  (w_lane),
        .i_det   (r_det_dly[mi3_pkg::DIV_LAT-1]),
        .o_ready (w_en),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_user  (w_user),
        .i_ready (i_m_axis_tready)
    );

    assign o_s_axis_tready   = w_en;
    assign o_m_axis_tuser[0] = w_user;

endmodule

// ===== rtl/mi3_checker.sv =====
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks of the matrix inverter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mi3_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [287:0] i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [319:0] o_m_axis_tdata,
    input logic [0:0]   o_m_axis_tuser
);

    // a stalled result beat stays put
    `MI3_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled output beat changed")

    // a singular beat carries all zeros
    `MI3_ASSERT(a_singular_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0, "singular beat has nonzero data")

    // reset empties the output
    `MI3_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind matrix3_inverse mi3_checker u_mi3_checker (.*);
